// ----- hdl/siva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siva_pkg
// Types and constants shared by the shift index vote accumulator modules.
// ----------------------------------------------------------------------------
package siva_pkg;

    localparam int SCORE_W   = 15;
    localparam int APPLIED_W = 17;
    localparam int PTR_W     = 17;
    localparam int ROWID_W   = 14;
    localparam int MASS_W    = 17;
    localparam int TOL_W     = 10;
    localparam int WEIGHT_W  = 8;
    localparam int CFG_W     = 15;
    localparam int SPAN_W    = 19;

    localparam logic [SCORE_W-1:0] SCORE_MAX    = 15'd32767;
    localparam logic [CFG_W-1:0]   ACTIVE_RESET = 15'd16384;

    typedef enum logic [2:0] {
        FUNC_LOAD_RANGE = 3'd0,
        FUNC_LOAD_ENTRY = 3'd1,
        FUNC_VOTE       = 3'd2,
        FUNC_CLEAR      = 3'd3,
        FUNC_READ       = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WIN,
        ST_PTR,
        ST_ENT_RD,
        ST_ENT_WAIT,
        ST_SC_WAIT,
        ST_RD_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             skip;
        logic [PTR_W-1:0] left;
        logic [PTR_W-1:0] right;
    } win_t;

endpackage

// ----- hdl/siva_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siva_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module siva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/siva_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siva_window
// Vote window: clamp the low end at zero and flag windows whose high end
// falls outside the active columns.
// ----------------------------------------------------------------------------
module siva_window #(
    parameter int COLUMNS = 16384
) (
    input  logic signed [siva_pkg::MASS_W-1:0] mass,
    input  logic [siva_pkg::TOL_W-1:0]         tolerance,
    input  logic [siva_pkg::CFG_W-1:0]         active_columns,
    output siva_pkg::win_t                     win
);
    import siva_pkg::*;

    logic signed [SPAN_W-1:0] lo;
    logic signed [SPAN_W-1:0] hi;
    logic [31:0]              hi_ext;

    always_comb begin
        lo     = SPAN_W'(mass) - $signed({{(SPAN_W-TOL_W){1'b0}}, tolerance});
        hi     = SPAN_W'(mass) + $signed({{(SPAN_W-TOL_W){1'b0}}, tolerance});
        hi_ext = 32'(unsigned'(hi));
        win.left  = lo[SPAN_W-1] ? '0 : lo[PTR_W-1:0];
        win.right = hi[PTR_W-1:0];
        win.skip  = hi[SPAN_W-1]
                 || (hi_ext >= 32'(active_columns))
                 || (hi_ext >= 32'(COLUMNS));
    end

endmodule

// ----- hdl/shift_index_vote_accumulator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_index_vote_accumulator_top
// Vote engine over a two-direction shift index with saturating row scores.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel; tuser carries the function code and
//   direction, tdata the operands. Every item returns one beat on m_axis:
//   the score read back, the number of rows voted and a skipped flag.
//   Loads and unused codes answer directly; a score read waits for the score
//   RAM's registered read. A vote reads its window's range pointers, then per
//   entry the row id and a read-modify-write of that row's score through one
//   saturating adder; rows at or beyond ROWS are passed over, and a skipped
//   window returns with no votes. A clear sweeps one direction's score RAM.
//   s_axis_tready is high only between items.
//   After reset both score RAMs are swept to zero while s_axis_tready stays
//   low; cfg_we writes are taken at any time out of reset.
//   A result waits in the output register while m_axis_tready is low; the
//   next item is then taken but its result holds until the beat leaves.
//   Index pointers and entries hold whatever was last loaded.
// ----------------------------------------------------------------------------
module shift_index_vote_accumulator_top #(
    parameter int COLUMNS = 16384,
    parameter int ENTRIES = 65536,
    parameter int ROWS    = 16384
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [14:0]   cfg_wdata,      // active_columns
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // column, range_first, range_last, entry_slot, row, mass, tolerance, weight
    input  logic [119:0]  s_axis_tdata,
    input  logic [3:0]    s_axis_tuser,   // func, direction
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata,   // read_score, votes_applied
    output logic [0:0]    m_axis_tuser    // skipped
);
    import siva_pkg::*;

    localparam int CW  = $clog2(COLUMNS);
    localparam int EW  = $clog2(ENTRIES);
    localparam int RW  = $clog2(ROWS);
    localparam int CAW = CW + 1;
    localparam int EAW = EW + 1;
    localparam int RAW = RW + 1;

    // input fields
    func_t                      s_func;
    logic                       s_dir;
    logic [13:0]                s_column;
    logic [PTR_W-1:0]           s_first;
    logic [PTR_W-1:0]           s_last;
    logic [15:0]                s_slot;
    logic [ROWID_W-1:0]         s_row;
    logic [MASS_W-1:0]          s_mass;
    logic [TOL_W-1:0]           s_tol;
    logic [WEIGHT_W-1:0]        s_weight;
    logic                       s_accept;
    logic [31:0]                col_ext;
    logic [31:0]                slot_ext;
    logic [31:0]                row_ext;

    assign s_func   = func_t'(s_axis_tuser[2:0]);
    assign s_dir    = s_axis_tuser[3];
    assign s_column = s_axis_tdata[13:0];
    assign s_first  = s_axis_tdata[30:14];
    assign s_last   = s_axis_tdata[47:31];
    assign s_slot   = s_axis_tdata[63:48];
    assign s_row    = s_axis_tdata[77:64];
    assign s_mass   = s_axis_tdata[94:78];
    assign s_tol    = s_axis_tdata[104:95];
    assign s_weight = s_axis_tdata[112:105];
    assign col_ext  = 32'(s_column);
    assign slot_ext = 32'(s_slot);
    assign row_ext  = 32'(s_row);

    // registers
    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      active_reg;
    logic                  dir_reg, dir_next;
    logic [MASS_W-1:0]     mass_reg, mass_next;
    logic [TOL_W-1:0]      tol_reg, tol_next;
    logic [WEIGHT_W-1:0]   weight_reg, weight_next;
    logic signed [SPAN_W-1:0] j_reg, j_next;
    logic signed [SPAN_W-1:0] end_reg, end_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [RW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  clr_both_reg, clr_both_next;
    logic                  boot_reg, boot_next;
    logic [APPLIED_W-1:0]  applied_reg, applied_next;
    logic [SCORE_W-1:0]    score_res_reg, score_res_next;
    logic                  skip_res_reg, skip_res_next;
    logic                  m_valid_reg, m_valid_next;
    logic [31:0]           m_data_reg, m_data_next;
    logic                  m_user_reg, m_user_next;

    // RAM ports
    logic                  range_we;
    logic [CAW-1:0]        range_waddr;
    logic [CAW-1:0]        first_raddr;
    logic [CAW-1:0]        last_raddr;
    logic [PTR_W-1:0]      first_rdata;
    logic [PTR_W-1:0]      last_rdata;
    logic                  entry_we;
    logic [EAW-1:0]        entry_waddr;
    logic [EAW-1:0]        entry_raddr;
    logic [ROWID_W-1:0]    entry_rdata;
    logic                  score_we;
    logic [RAW-1:0]        score_waddr;
    logic [SCORE_W-1:0]    score_wdata;
    logic [RAW-1:0]        score_raddr;
    logic [SCORE_W-1:0]    score_rdata;

    win_t                  win;
    logic [31:0]           left_ext;
    logic [31:0]           right_ext;
    logic [31:0]           j_ext;
    logic [31:0]           erow_ext;
    logic [15:0]           sum;
    logic                  j_live;

    siva_window #(
        .COLUMNS(COLUMNS)
    ) u_window (
        .mass           (mass_reg),
        .tolerance      (tol_reg),
        .active_columns (active_reg),
        .win            (win)
    );

    assign left_ext    = 32'(win.left);
    assign right_ext   = 32'(win.right);
    assign j_ext       = 32'(j_reg);
    assign erow_ext    = 32'(entry_rdata);
    assign range_waddr = {s_dir, col_ext[CW-1:0]};
    assign first_raddr = {dir_reg, left_ext[CW-1:0]};
    assign last_raddr  = {dir_reg, right_ext[CW-1:0]};
    assign entry_waddr = {s_dir, slot_ext[EW-1:0]};
    assign entry_raddr = {dir_reg, j_ext[EW-1:0]};
    assign score_raddr = (state_reg == ST_IDLE) ? {s_dir, row_ext[RW-1:0]}
                                                : {dir_reg, erow_ext[RW-1:0]};
    assign sum         = {1'b0, score_rdata} + {{(16-WEIGHT_W){1'b0}}, weight_reg};
    assign j_live      = (j_reg <= end_reg) && (j_ext < 32'(ENTRIES));

    siva_ram #(.WIDTH(PTR_W), .DEPTH(2 ** CAW)) u_first_ram (
        .aclk (aclk), .we (range_we), .waddr (range_waddr), .wdata (s_first),
        .raddr (first_raddr), .rdata (first_rdata)
    );

    siva_ram #(.WIDTH(PTR_W), .DEPTH(2 ** CAW)) u_last_ram (
        .aclk (aclk), .we (range_we), .waddr (range_waddr), .wdata (s_last),
        .raddr (last_raddr), .rdata (last_rdata)
    );

    siva_ram #(.WIDTH(ROWID_W), .DEPTH(2 ** EAW)) u_entry_ram (
        .aclk (aclk), .we (entry_we), .waddr (entry_waddr), .wdata (s_row),
        .raddr (entry_raddr), .rdata (entry_rdata)
    );

    siva_ram #(.WIDTH(SCORE_W), .DEPTH(2 ** RAW)) u_score_ram (
        .aclk (aclk), .we (score_we), .waddr (score_waddr), .wdata (score_wdata),
        .raddr (score_raddr), .rdata (score_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            active_reg   <= ACTIVE_RESET;
            dir_reg      <= 1'b0;
            clr_cnt_reg  <= '0;
            clr_both_reg <= 1'b1;
            boot_reg     <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                active_reg <= cfg_wdata;
            end
            dir_reg      <= dir_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_both_reg <= clr_both_next;
            boot_reg     <= boot_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mass_reg      <= mass_next;
        tol_reg       <= tol_next;
        weight_reg    <= weight_next;
        j_reg         <= j_next;
        end_reg       <= end_next;
        r_reg         <= r_next;
        applied_reg   <= applied_next;
        score_res_reg <= score_res_next;
        skip_res_reg  <= skip_res_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    always_comb begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        mass_next      = mass_reg;
        tol_next       = tol_reg;
        weight_next    = weight_reg;
        j_next         = j_reg;
        end_next       = end_reg;
        r_next         = r_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_both_next  = clr_both_reg;
        boot_next      = boot_reg;
        applied_next   = applied_reg;
        score_res_next = score_res_reg;
        skip_res_next  = skip_res_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        range_we       = 1'b0;
        entry_we       = 1'b0;
        score_we       = 1'b0;
        score_waddr    = {dir_reg, r_reg};
        score_wdata    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    dir_next       = s_dir;
                    mass_next      = s_mass;
                    tol_next       = s_tol;
                    weight_next    = s_weight;
                    applied_next   = '0;
                    score_res_next = '0;
                    skip_res_next  = 1'b0;
                    state_next     = ST_RESULT;
                    unique case (s_func)
                        FUNC_LOAD_RANGE: range_we = (col_ext < 32'(COLUMNS));
                        FUNC_LOAD_ENTRY: entry_we = (slot_ext < 32'(ENTRIES));
                        FUNC_VOTE:       state_next = ST_WIN;
                        FUNC_CLEAR: begin
                            clr_cnt_next  = '0;
                            clr_both_next = 1'b0;
                            state_next    = ST_CLEAR;
                        end
                        FUNC_READ: begin
                            if (row_ext < 32'(ROWS)) begin
                                state_next = ST_RD_WAIT;
                            end
                        end
                        default: state_next = ST_RESULT;
                    endcase
                end
            end
            ST_CLEAR: begin
                score_we    = 1'b1;
                score_waddr = {dir_reg, clr_cnt_reg};
                if (32'(clr_cnt_reg) == 32'(ROWS - 1)) begin
                    clr_cnt_next = '0;
                    if (clr_both_reg) begin
                        clr_both_next = 1'b0;
                        dir_next      = 1'b1;
                    end else begin
                        boot_next  = 1'b0;
                        state_next = boot_reg ? ST_IDLE : ST_RESULT;
                    end
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_WIN: begin
                if (win.skip) begin
                    skip_res_next = 1'b1;
                    state_next    = ST_RESULT;
                end else begin
                    state_next = ST_PTR;
                end
            end
            ST_PTR: begin
                j_next     = SPAN_W'(first_rdata);
                end_next   = SPAN_W'($signed(last_rdata));
                state_next = ST_ENT_RD;
            end
            ST_ENT_RD: begin
                state_next = j_live ? ST_ENT_WAIT : ST_RESULT;
            end
            ST_ENT_WAIT: begin
                j_next = j_reg + 1'b1;
                if (erow_ext < 32'(ROWS)) begin
                    r_next     = erow_ext[RW-1:0];
                    state_next = ST_SC_WAIT;
                end else begin
                    state_next = ST_ENT_RD;
                end
            end
            ST_SC_WAIT: begin
                score_we     = 1'b1;
                score_wdata  = sum[15] ? SCORE_MAX : sum[SCORE_W-1:0];
                applied_next = applied_reg + 1'b1;
                state_next   = ST_ENT_RD;
            end
            ST_RD_WAIT: begin
                score_res_next = score_rdata;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {applied_reg, score_res_reg};
                    m_user_next  = skip_res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
